@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/twa_pkg.sv @@
`timescale 1ns / 1ps

package twa_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int BOX_TYPES   = 64;
  localparam int LOAD_BITS   = 16;
  localparam int WORKER_BITS = 4;
  localparam int TYPE_BITS   = 6;
  localparam int CNT_BITS    = 5;
  localparam int GROUP_SIZE  = 4;
  localparam int GROUPS      = (MAX_WORKERS + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic [LOAD_BITS-1:0]   load_t;
  typedef logic [WORKER_BITS-1:0] worker_t;
  typedef logic [TYPE_BITS-1:0]   type_idx_t;
  typedef logic [CNT_BITS-1:0]    count_t;

  localparam count_t CNT_RESET = count_t'(MAX_WORKERS);

  function automatic count_t active_count(count_t raw);
    count_t n;
    n = raw;
    if (raw == '0) begin
      n = count_t'(1);
    end else if (raw > count_t'(MAX_WORKERS)) begin
      n = count_t'(MAX_WORKERS);
    end
    return n;
  endfunction

endpackage

@@ sv/twa_if.sv @@
`timescale 1ns / 1ps

interface twa_req_if;
  logic                  valid;
  logic                  ready;
  logic                  is_box;
  twa_pkg::type_idx_t    box_type;

  modport source (output valid, output is_box, output box_type, input ready);
  modport sink   (input valid, input is_box, input box_type, output ready);
endinterface

interface twa_rsp_if;
  logic                  valid;
  logic                  ready;
  twa_pkg::worker_t      worker;

  modport source (output valid, output worker, input ready);
  modport sink   (input valid, input worker, output ready);
endinterface

@@ sv/twa_ram.sv @@
`timescale 1ns / 1ps

module twa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/task_worker_assigner_unit.sv @@
`timescale 1ns / 1ps
// Task worker assigner.
// req channel (valid/ready): is_box and box_type of one task per transaction.
// rsp channel (valid/ready): the worker index picked for that task.
// cfg_we/cfg_wdata: writes worker_count; clears all assignment state at once.
// Box tasks of a type rotate through workers from a per-type round pointer kept
// in a 64-entry synchronous RAM; the first task of a type seeds the pointer
// with the least-loaded worker (ties to the lowest index). Non-box tasks rotate
// through one shared pointer that starts at the last worker.
// Steps: the accepting cycle reads the round RAM and the first level of the
// min-load tree into registers, S_LOOK finishes the tree, and S_ASSIGN resolves
// the target, writes back RAM and load, and registers the result.
// A new task is not taken until that read/modify/write sequence is done.
// req.ready is high only between tasks.
// When the receiver stalls, the result is held in the output register and the
// next task waits in its write-back step until the register frees.
// Reset: worker_count 16, all types unseen, loads zero, shared pointer at 15,
// no result pending.
module task_worker_assigner_unit (
  input  logic                   clk,
  input  logic                   rst,
  twa_req_if.sink                req,
  twa_rsp_if.source              rsp,
  input  logic                   cfg_we,
  input  twa_pkg::count_t        cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_ASSIGN} state_t;

  state_t                        state;
  twa_pkg::count_t               worker_count;
  twa_pkg::count_t               n_eff;
  logic [twa_pkg::BOX_TYPES-1:0] type_seen;
  twa_pkg::load_t                worker_load [twa_pkg::MAX_WORKERS];
  twa_pkg::worker_t              plain_next;
  logic                          out_valid;
  twa_pkg::worker_t              out_worker;

  logic                          cur_box;
  twa_pkg::type_idx_t            cur_type;
  logic                          grp_ok   [twa_pkg::GROUPS];
  twa_pkg::load_t                grp_load [twa_pkg::GROUPS];
  twa_pkg::worker_t              grp_idx  [twa_pkg::GROUPS];
  twa_pkg::worker_t              min_idx;

  logic                          grp_ok_next   [twa_pkg::GROUPS];
  twa_pkg::load_t                grp_load_next [twa_pkg::GROUPS];
  twa_pkg::worker_t              grp_idx_next  [twa_pkg::GROUPS];
  twa_pkg::worker_t              min_idx_next;

  twa_pkg::worker_t              round_rdata;
  twa_pkg::worker_t              pick;
  twa_pkg::worker_t              target;
  twa_pkg::count_t               target_inc;
  twa_pkg::worker_t              target_adv;
  logic                          accept;
  logic                          fire;

  assign n_eff     = twa_pkg::active_count(worker_count);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_ASSIGN) && (!out_valid || rsp.ready);
  assign rsp.valid  = out_valid;
  assign rsp.worker = out_worker;

  twa_ram #(
    .WIDTH (twa_pkg::WORKER_BITS),
    .DEPTH (twa_pkg::BOX_TYPES)
  ) u_round_ram (
    .clk   (clk),
    .we    (fire && cur_box),
    .waddr (cur_type),
    .wdata (target_adv),
    .re    (accept),
    .raddr (req.box_type),
    .rdata (round_rdata)
  );

  always_comb begin
    for (int g = 0; g < twa_pkg::GROUPS; g++) begin
      grp_ok_next[g]   = 1'b0;
      grp_load_next[g] = '0;
      grp_idx_next[g]  = '0;
      for (int k = 0; k < twa_pkg::GROUP_SIZE; k++) begin
        if ((g * twa_pkg::GROUP_SIZE + k < twa_pkg::MAX_WORKERS) &&
            (g * twa_pkg::GROUP_SIZE + k < int'(n_eff))) begin
          if (!grp_ok_next[g] ||
              (worker_load[g * twa_pkg::GROUP_SIZE + k] < grp_load_next[g])) begin
            grp_ok_next[g]   = 1'b1;
            grp_load_next[g] = worker_load[g * twa_pkg::GROUP_SIZE + k];
            grp_idx_next[g]  = twa_pkg::WORKER_BITS'(g * twa_pkg::GROUP_SIZE + k);
          end
        end
      end
    end
  end

  always_comb begin
    logic           best_ok;
    twa_pkg::load_t best_load;
    best_ok      = 1'b0;
    best_load    = '0;
    min_idx_next = '0;
    for (int g = 0; g < twa_pkg::GROUPS; g++) begin
      if (grp_ok[g] && (!best_ok || (grp_load[g] < best_load))) begin
        best_ok      = 1'b1;
        best_load    = grp_load[g];
        min_idx_next = grp_idx[g];
      end
    end
  end

  always_comb begin
    if (cur_box) begin
      pick = type_seen[cur_type] ? round_rdata : min_idx;
    end else begin
      pick = plain_next;
    end
    target     = (twa_pkg::count_t'(pick) >= n_eff) ? '0 : pick;
    target_inc = twa_pkg::count_t'(target) + twa_pkg::count_t'(1);
    target_adv = (target_inc >= n_eff) ? '0 : target_inc[twa_pkg::WORKER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_box  <= req.is_box;
      cur_type <= req.box_type;
      grp_ok   <= grp_ok_next;
      grp_load <= grp_load_next;
      grp_idx  <= grp_idx_next;
    end
    if (state == S_LOOK) begin
      min_idx <= min_idx_next;
    end
    if (fire) begin
      out_worker <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      worker_count <= twa_pkg::CNT_RESET;
      type_seen    <= '0;
      for (int i = 0; i < twa_pkg::MAX_WORKERS; i++) begin
        worker_load[i] <= '0;
      end
      plain_next   <= twa_pkg::WORKER_BITS'(twa_pkg::MAX_WORKERS - 1);
      out_valid    <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && !rsp.ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_ASSIGN;
        end
        S_ASSIGN: begin
          if (fire) begin
            state     <= S_IDLE;
            if (cur_box) begin
              type_seen[cur_type] <= 1'b1;
              if (worker_load[target] != {twa_pkg::LOAD_BITS{1'b1}}) begin
                worker_load[target] <= worker_load[target] + twa_pkg::load_t'(1);
              end
            end else begin
              plain_next <= target_adv;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        worker_count <= cfg_wdata;
        type_seen    <= '0;
        for (int i = 0; i < twa_pkg::MAX_WORKERS; i++) begin
          worker_load[i] <= '0;
        end
        plain_next <= twa_pkg::WORKER_BITS'(twa_pkg::active_count(cfg_wdata)
                                             - twa_pkg::count_t'(1));
      end
    end
  end

endmodule

@@ sv/twa_chk.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twa_chk (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input twa_pkg::worker_t worker,
  input logic             cfg_we,
  input twa_pkg::count_t  cfg_wdata
);

  twa_pkg::count_t count_seen;
  twa_pkg::count_t n_eff;

  assign n_eff = twa_pkg::active_count(count_seen);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_seen <= twa_pkg::CNT_RESET;
    end else if (cfg_we) begin
      count_seen <= cfg_wdata;
    end
  end

  `ASSERT_IMPLY(a_worker_in_range, clk, rst, rsp_valid, twa_pkg::count_t'(worker) < n_eff)
  `ASSERT_NEXT(a_one_task_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `ASSERT_NEXT(a_worker_hold, clk, rst, rsp_valid && !rsp_ready, $stable(worker))

endmodule

bind task_worker_assigner_unit twa_chk u_twa_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .worker    (rsp.worker),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata)
);

@@ tb/task_worker_assigner_unit_test.sv @@
`timescale 1ns / 1ps

module task_worker_assigner_unit_test;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int CHUNK_ITEMS = 130;

  typedef enum logic {ROW_TASK, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               box;
    twa_pkg::type_idx_t bt;
    twa_pkg::count_t    cnt;
    logic               given;
    twa_pkg::worker_t   want;
  } step_row_t;

  localparam int DIR_ROWS = 27;
  localparam step_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_TASK,  1'b0, 6'd0,  5'd0,  1'b1, 4'd15},
    '{ROW_TASK,  1'b0, 6'd63, 5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b1, 6'd0,  5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b1, 6'd0,  5'd0,  1'b1, 4'd1},
    '{ROW_TASK,  1'b1, 6'd63, 5'd0,  1'b1, 4'd2},
    '{ROW_TASK,  1'b1, 6'd42, 5'd0,  1'b0, 4'd0},
    '{ROW_TASK,  1'b1, 6'd63, 5'd0,  1'b0, 4'd0},
    '{ROW_COUNT, 1'b0, 6'd0,  5'd0,  1'b0, 4'd0},
    '{ROW_TASK,  1'b1, 6'd21, 5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b0, 6'd42, 5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b1, 6'd21, 5'd0,  1'b1, 4'd0},
    '{ROW_COUNT, 1'b0, 6'd0,  5'd31, 1'b0, 4'd0},
    '{ROW_TASK,  1'b0, 6'd0,  5'd0,  1'b1, 4'd15},
    '{ROW_TASK,  1'b1, 6'd7,  5'd0,  1'b1, 4'd0},
    '{ROW_COUNT, 1'b0, 6'd0,  5'd17, 1'b0, 4'd0},
    '{ROW_TASK,  1'b0, 6'd0,  5'd0,  1'b1, 4'd15},
    '{ROW_COUNT, 1'b0, 6'd0,  5'd1,  1'b0, 4'd0},
    '{ROW_TASK,  1'b1, 6'd0,  5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b0, 6'd0,  5'd0,  1'b1, 4'd0},
    '{ROW_COUNT, 1'b0, 6'd0,  5'd3,  1'b0, 4'd0},
    '{ROW_TASK,  1'b0, 6'd0,  5'd0,  1'b1, 4'd2},
    '{ROW_TASK,  1'b0, 6'd0,  5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b1, 6'd0,  5'd0,  1'b1, 4'd0},
    '{ROW_TASK,  1'b1, 6'd1,  5'd0,  1'b1, 4'd1},
    '{ROW_TASK,  1'b1, 6'd0,  5'd0,  1'b0, 4'd0},
    '{ROW_TASK,  1'b1, 6'd62, 5'd0,  1'b0, 4'd0},
    '{ROW_COUNT, 1'b0, 6'd0,  5'd16, 1'b0, 4'd0}
  };

  localparam twa_pkg::count_t COUNT_PICKS [8] =
    '{5'd0, 5'd1, 5'd2, 5'd3, 5'd15, 5'd16, 5'd17, 5'd31};

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  twa_pkg::count_t cfg_wdata;

  twa_req_if req_ch ();
  twa_rsp_if rsp_ch ();

  task_worker_assigner_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  twa_pkg::count_t  count_raw;
  bit               type_seen [twa_pkg::BOX_TYPES];
  twa_pkg::worker_t type_round [twa_pkg::BOX_TYPES];
  twa_pkg::load_t   worker_load [twa_pkg::MAX_WORKERS];
  twa_pkg::worker_t plain_next;

  twa_pkg::worker_t pending_workers [$];
  int               mismatches = 0;
  int               stall_cycles = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  twa_pkg::worker_t head_worker;

  function automatic int workers_in_use();
    if (count_raw == '0) begin
      return 1;
    end
    if (int'(count_raw) > twa_pkg::MAX_WORKERS) begin
      return twa_pkg::MAX_WORKERS;
    end
    return int'(count_raw);
  endfunction

  function automatic void clear_assignments(twa_pkg::count_t raw);
    count_raw = raw;
    for (int i = 0; i < twa_pkg::BOX_TYPES; i++) begin
      type_seen[i] = 1'b0;
      type_round[i] = '0;
    end
    for (int i = 0; i < twa_pkg::MAX_WORKERS; i++) begin
      worker_load[i] = '0;
    end
    plain_next = twa_pkg::worker_t'(workers_in_use() - 1);
  endfunction

  function automatic twa_pkg::worker_t pick_worker(logic box, twa_pkg::type_idx_t bt);
    int n;
    int target;
    int best;
    n = workers_in_use();
    if (box) begin
      if (!type_seen[bt]) begin
        best = 0;
        for (int i = 1; i < n; i++) begin
          if (worker_load[i] < worker_load[best]) begin
            best = i;
          end
        end
        type_seen[bt] = 1'b1;
        type_round[bt] = twa_pkg::worker_t'(best);
      end
      target = int'(type_round[bt]);
      if (target >= n) begin
        target = 0;
      end
      type_round[bt] = twa_pkg::worker_t'((target + 1 >= n) ? 0 : target + 1);
      if (worker_load[target] != {twa_pkg::LOAD_BITS{1'b1}}) begin
        worker_load[target] = worker_load[target] + twa_pkg::load_t'(1);
      end
    end else begin
      target = int'(plain_next);
      if (target >= n) begin
        target = 0;
      end
      plain_next = twa_pkg::worker_t'((target + 1 >= n) ? 0 : target + 1);
    end
    return twa_pkg::worker_t'(target);
  endfunction

  task automatic dispatch_task(input logic box, input twa_pkg::type_idx_t bt,
                               input logic given, input twa_pkg::worker_t want);
    twa_pkg::worker_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.is_box <= box;
    req_ch.box_type <= bt;
    do @(posedge clk); while (!req_ch.ready);
    predicted = pick_worker(box, bt);
    pending_workers.push_back(given ? want : predicted);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_workers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_worker_count(input twa_pkg::count_t value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_assignments(value);
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_workers.size() == 0) begin
        if (mismatches < 100) begin
          $display("%0t: unexpected transaction, expected none, actual %0d",
                   $time, rsp_ch.worker);
        end
        mismatches++;
      end else begin
        head_worker = pending_workers.pop_front();
        if (rsp_ch.worker !== head_worker) begin
          if (mismatches < 100) begin
            $display("%0t: worker mismatch, expected %0d, actual %0d",
                     $time, head_worker, rsp_ch.worker);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    twa_pkg::type_idx_t pool_base;
    int                 pool_span;
    logic               box;
    twa_pkg::type_idx_t bt;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = twa_pkg::CNT_RESET;
    req_ch.valid = 1'b0;
    req_ch.is_box = 1'b0;
    req_ch.box_type = '0;
    rsp_ch.ready = 1'b0;
    clear_assignments(twa_pkg::CNT_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_COUNT) begin
        write_worker_count(DIRECTED[r].cnt);
      end else begin
        dispatch_task(DIRECTED[r].box, DIRECTED[r].bt, DIRECTED[r].given,
                      DIRECTED[r].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 8 : 0;
      for (int c = 0; c < 5; c++) begin
        if ($urandom_range(1) == 0) begin
          write_worker_count(COUNT_PICKS[$urandom_range(7)]);
        end else begin
          write_worker_count(twa_pkg::count_t'($urandom_range(31)));
        end
        pool_base = twa_pkg::type_idx_t'($urandom_range(63));
        pool_span = $urandom_range(6, 1);
        for (int k = 0; k < CHUNK_ITEMS; k++) begin
          box = ($urandom_range(99) < 70);
          if ($urandom_range(99) < 80) begin
            bt = pool_base + twa_pkg::type_idx_t'($urandom_range(pool_span - 1));
          end else begin
            bt = twa_pkg::type_idx_t'($urandom_range(63));
          end
          dispatch_task(box, bt, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_workers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
